// ----- hw/rtl/spq_pkg.sv -----
// ----------------------------------------------------------------------------
// spq_pkg: shared types and constants of the sorted priority queue
// Word layouts of the request and response channels, the entry held in a
// cell and the control word broadcast along the cell chain.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int QUEUE_DEPTH   = 16;
    localparam int PRIORITY_BITS = 16;
    localparam int PAYLOAD_BITS  = 32;
    localparam int CAP_BITS      = 5;
    localparam int COUNT_BITS    = 5;
    localparam int CAP_RESET     = 16;

    typedef enum logic
    {
        OP_ENQ = 1'b0,
        OP_DEQ = 1'b1
    } op_t;

    typedef enum logic [1:0]
    {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef struct packed
    {
        op_t                      opcode;
        logic [PRIORITY_BITS-1:0] priority_req;
        logic [PAYLOAD_BITS-1:0]  payload;
    } req_t;

    typedef struct packed
    {
        status_t                  status;
        logic [PRIORITY_BITS-1:0] out_priority;
        logic [PAYLOAD_BITS-1:0]  out_payload;
        logic [COUNT_BITS-1:0]    entry_count;
        logic                     is_empty;
        logic                     is_full;
    } rsp_t;

    typedef struct packed
    {
        logic [PRIORITY_BITS-1:0] prio;
        logic [PAYLOAD_BITS-1:0]  data;
    } entry_t;

    typedef struct packed
    {
        logic   enq;
        logic   deq;
        entry_t entry;
    } cell_ctrl_t;

endpackage

// ----- hw/rtl/sorted_priority_queue_unit.sv -----
// ----------------------------------------------------------------------------
// sorted_priority_queue_unit: insertion-sorted bounded priority queue
// Holds priority/payload entries in a row of compare-and-shift cells with
// the smallest priority in cell 0.
// ----------------------------------------------------------------------------
//
//  Channel | Handshake             | Word                 | Direction
//  --------+-----------------------+----------------------+----------
//  req     | req_valid / req_ready | spq_pkg::req_t       | in
//  rsp     | rsp_valid / rsp_ready | spq_pkg::rsp_t       | out
//  cfg     | cfg_valid / cfg_ready | capacity_in_use, 5 b | in
//
//  Each request word is handled in the cycle it is accepted; its response
//  word sits in the output register from the next cycle on. With rsp_ready
//  high the unit takes one request word per cycle; the cell row updates on
//  each accepted word, and the single output register sets that rate.
//  A response not taken stalls the request side until it drains.
//  Reset empties the queue and sets capacity to 16; no clearing pass runs,
//  since cells beyond the count are never read.
//
module sorted_priority_queue_unit
#(
    parameter int QUEUE_DEPTH = spq_pkg::QUEUE_DEPTH
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           req_valid,
    output logic                           req_ready,
    input  spq_pkg::req_t                  req,
    output logic                           rsp_valid,
    input  logic                           rsp_ready,
    output spq_pkg::rsp_t                  rsp,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [spq_pkg::CAP_BITS-1:0]   cfg_data
);

    localparam int CntW   = $clog2(QUEUE_DEPTH + 1);
    localparam int CapW   = spq_pkg::CAP_BITS;
    localparam int CmpW   = (CntW > CapW) ? CntW : CapW;
    localparam int CountW = spq_pkg::COUNT_BITS;

    // Control state.
    logic [CntW-1:0]     count_reg;
    logic [CntW-1:0]     count_next;
    logic [CapW-1:0]     cap_reg;
    logic                rsp_valid_reg;
    logic                rsp_valid_next;

    // Output word register.
    spq_pkg::rsp_t       rsp_reg;
    spq_pkg::rsp_t       rsp_next;

    // Cell row wiring.
    spq_pkg::cell_ctrl_t cell_ctrl;
    spq_pkg::entry_t     cell_entry [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] take_vec;

    logic                accept;
    logic [CmpW-1:0]     cap_eff;
    logic [CmpW-1:0]     count_ext;
    logic [CmpW-1:0]     count_next_ext;

    // Take a new request whenever the output register is free or draining.
    assign req_ready = !rsp_valid_reg || rsp_ready;
    assign accept    = req_valid && req_ready;
    assign cfg_ready = 1'b1;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Clamp capacity: zero acts as one, above the depth acts as the depth.
    always_comb
    begin
        if (cap_reg == '0)
        begin
            cap_eff = CmpW'(1);
        end
        else if (CmpW'(cap_reg) > CmpW'(QUEUE_DEPTH))
        begin
            cap_eff = CmpW'(QUEUE_DEPTH);
        end
        else
        begin
            cap_eff = CmpW'(cap_reg);
        end
    end

    assign count_ext      = CmpW'(count_reg);
    assign count_next_ext = CmpW'(count_next);

    // Decode the accepted word: drive the cell row and build the response.
    always_comb
    begin
        cell_ctrl.enq        = 1'b0;
        cell_ctrl.deq        = 1'b0;
        cell_ctrl.entry.prio = req.priority_req;
        cell_ctrl.entry.data = req.payload;
        count_next           = count_reg;
        rsp_next.status       = spq_pkg::ST_DONE;
        rsp_next.out_priority = '0;
        rsp_next.out_payload  = '0;
        if (accept)
        begin
            case (req.opcode)
                spq_pkg::OP_ENQ:
                begin
                    if (count_ext >= cap_eff)
                    begin
                        rsp_next.status = spq_pkg::ST_FULL;
                    end
                    else
                    begin
                        cell_ctrl.enq = 1'b1;
                        count_next    = count_reg + CntW'(1);
                    end
                end
                spq_pkg::OP_DEQ:
                begin
                    if (count_reg == '0)
                    begin
                        rsp_next.status = spq_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        // Hand out the head and shift the row toward it.
                        cell_ctrl.deq         = 1'b1;
                        rsp_next.out_priority = cell_entry[0].prio;
                        rsp_next.out_payload  = cell_entry[0].data;
                        count_next            = count_reg - CntW'(1);
                    end
                end
                default:
                begin
                end
            endcase
        end
        rsp_next.entry_count = CountW'(count_next);
        rsp_next.is_empty    = (count_next == '0);
        rsp_next.is_full     = (count_next_ext >= cap_eff);
    end

    // Hold the response until taken; load a new one on every accept.
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (accept)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            cap_reg       <= CapW'(spq_pkg::CAP_RESET);
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                cap_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rsp_reg <= rsp_next;
        end
    end

    // Cell row: cell 0 is the head, each cell sees both neighbors.
    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        logic            left_take;
        spq_pkg::entry_t left_entry;
        spq_pkg::entry_t right_entry;

        if (i == 0)
        begin : g_head
            assign left_take  = 1'b0;
            assign left_entry = '0;
        end
        else
        begin : g_body
            assign left_take  = take_vec[i-1];
            assign left_entry = cell_entry[i-1];
        end

        if (i == QUEUE_DEPTH - 1)
        begin : g_tail
            assign right_entry = cell_entry[i];
        end
        else
        begin : g_mid
            assign right_entry = cell_entry[i+1];
        end

        spq_cell u_cell
        (
            .clk         (clk),
            .ctrl        (cell_ctrl),
            .occupied    (count_reg > CntW'(i)),
            .left_take   (left_take),
            .left_entry  (left_entry),
            .right_entry (right_entry),
            .take        (take_vec[i]),
            .entry       (cell_entry[i])
        );
    end

endmodule

// ----- hw/rtl/spq_cell.sv -----
// ----------------------------------------------------------------------------
// spq_cell: one slot of the sorted queue
// Compares its entry with the incoming priority; on insert it loads the new
// entry or its left neighbor's, on removal it loads its right neighbor's.
// ----------------------------------------------------------------------------
module spq_cell
(
    input  logic                clk,
    input  spq_pkg::cell_ctrl_t ctrl,
    input  logic                occupied,
    input  logic                left_take,
    input  spq_pkg::entry_t     left_entry,
    input  spq_pkg::entry_t     right_entry,
    output logic                take,
    output spq_pkg::entry_t     entry
);

    spq_pkg::entry_t entry_reg;
    spq_pkg::entry_t entry_next;

    // At or behind the insert point: empty, or priority not below the new one.
    assign take  = !(occupied && (entry_reg.prio < ctrl.entry.prio));
    assign entry = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.enq)
        begin
            if (take)
            begin
                entry_next = left_take ? left_entry : ctrl.entry;
            end
        end
        else if (ctrl.deq)
        begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

// ----- hw/rtl/spq_checker.sv -----
// ----------------------------------------------------------------------------
// spq_checker: port-level checks for the sorted priority queue
// Watches the request and response channels of the top level.
// ----------------------------------------------------------------------------
module spq_checker
(
    input logic          clk,
    input logic          rst_n,
    input logic          req_valid,
    input logic          req_ready,
    input spq_pkg::req_t req,
    input logic          rsp_valid,
    input logic          rsp_ready,
    input spq_pkg::rsp_t rsp
);

    // Flags agree with the reported count.
    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp.is_empty == (rsp.entry_count == '0)))
        else $error("is_empty disagrees with entry_count");

    // A refused insert always reports a full queue.
    a_full_refusal: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (rsp.status == spq_pkg::ST_FULL)) |-> rsp.is_full)
        else $error("full refusal without is_full");

    // Every accepted word yields a response on the next cycle.
    a_rsp_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> rsp_valid)
        else $error("no response after accepted request");

    // An insert never returns an entry.
    a_enq_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready && (req.opcode == spq_pkg::OP_ENQ))
        |=> ((rsp.out_priority == '0) && (rsp.out_payload == '0)))
        else $error("insert response carries an entry");

    // A stalled response holds.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp)))
        else $error("stalled response changed");

endmodule

bind sorted_priority_queue_unit spq_checker u_spq_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb: self-checking bench for sorted_priority_queue_unit
// Drives enqueue and dequeue request words through the valid/ready request
// channel and writes the capacity register over the cfg channel. A shadow
// queue in the bench predicts every response word. The bench compares each
// accepted response field by field with the oldest prediction. Random idling
// and stalls on both sides, plus a long output hold-off, exercise the handshakes.
// ----------------------------------------------------------------------------
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    // Cycles with no handshake on any channel before the run is declared hung.
    localparam int QUIET_LIMIT = 5000;

    logic                         clk;
    logic                         rst_n;
    logic                         req_valid;
    logic                         req_ready;
    spq_pkg::req_t                req;
    logic                         rsp_valid;
    logic                         rsp_ready;
    spq_pkg::rsp_t                rsp;
    logic                         cfg_valid;
    logic                         cfg_ready;
    logic [spq_pkg::CAP_BITS-1:0] cfg_data;

    // Shadow copy of the queue: sorted entries, count and capacity register.
    spq_pkg::entry_t              shadow_slot [spq_pkg::QUEUE_DEPTH];
    int                           shadow_count;
    logic [spq_pkg::CAP_BITS-1:0] shadow_cap;

    // Predicted response words, oldest first.
    spq_pkg::rsp_t                pending_rsp [$];

    int                           error_count;
    int                           quiet_cycles;
    int                           send_idle_pct;
    int                           recv_stall_pct;
    int                           hold_remaining;

    sorted_priority_queue_unit uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    // ------------------------------------------------------------------------
    // Shadow queue
    // ------------------------------------------------------------------------

    // Apply one request word to the shadow queue and return the response
    // word the unit must produce for it.
    function automatic spq_pkg::rsp_t apply_queue_op(input spq_pkg::req_t w);
        spq_pkg::rsp_t res;
        int            eff_cap;
        int            pos;
        int            k;
        // Clamp the capacity: zero acts as one, anything past the depth as
        // the depth.
        if (shadow_cap == '0)
            eff_cap = 1;
        else if (int'(shadow_cap) > spq_pkg::QUEUE_DEPTH)
            eff_cap = spq_pkg::QUEUE_DEPTH;
        else
            eff_cap = int'(shadow_cap);
        res        = '0;
        res.status = spq_pkg::ST_DONE;
        if (w.opcode == spq_pkg::OP_ENQ)
        begin
            // Refuse while at or above capacity, also after capacity is lowered.
            if (shadow_count >= eff_cap)
                res.status = spq_pkg::ST_FULL;
            else
            begin
                // Insert ahead of every entry of equal or greater priority.
                pos = 0;
                while (pos < shadow_count && shadow_slot[pos].prio < w.priority_req)
                    pos++;
                for (k = shadow_count; k > pos; k--)
                    shadow_slot[k] = shadow_slot[k - 1];
                shadow_slot[pos].prio = w.priority_req;
                shadow_slot[pos].data = w.payload;
                shadow_count++;
            end
        end
        else
        begin
            if (shadow_count == 0)
                res.status = spq_pkg::ST_EMPTY;
            else
            begin
                res.out_priority = shadow_slot[0].prio;
                res.out_payload  = shadow_slot[0].data;
                for (k = 1; k < shadow_count; k++)
                    shadow_slot[k - 1] = shadow_slot[k];
                shadow_count--;
            end
        end
        res.entry_count = shadow_count[spq_pkg::COUNT_BITS-1:0];
        res.is_empty    = (shadow_count == 0);
        res.is_full     = (shadow_count >= eff_cap);
        return res;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            error_count++;
        end
    endtask

    // ------------------------------------------------------------------------
    // Monitor: sample every channel at the rising edge. A request word
    // accepted here yields its response no earlier than the next edge, so
    // check the response before the prediction is queued.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        spq_pkg::rsp_t want;
        if (rst_n)
        begin
            if (rsp_valid && rsp_ready)
            begin
                if (pending_rsp.size() == 0)
                begin
                    $display("%0t ns: unexpected response word, expected none, actual %0h",
                             $time, rsp);
                    error_count++;
                end
                else
                begin
                    want = pending_rsp.pop_front();
                    check_field("status",       32'(want.status),       32'(rsp.status));
                    check_field("out_priority", 32'(want.out_priority), 32'(rsp.out_priority));
                    check_field("out_payload",  32'(want.out_payload),  32'(rsp.out_payload));
                    check_field("entry_count",  32'(want.entry_count),  32'(rsp.entry_count));
                    check_field("is_empty",     32'(want.is_empty),     32'(rsp.is_empty));
                    check_field("is_full",      32'(want.is_full),      32'(rsp.is_full));
                end
            end
            if (req_valid && req_ready)
                pending_rsp.push_back(apply_queue_op(req));
            if (cfg_valid && cfg_ready)
                shadow_cap = cfg_data;
        end
    end

    // Watchdog: count cycles with no handshake anywhere and end a hung run.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_valid && req_ready) || (rsp_valid && rsp_ready) ||
                (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // Receiver: stall at random, or hold off completely while a hold-off is
    // counting down.
    always @(posedge clk)
    begin
        if (hold_remaining > 0)
        begin
            rsp_ready <= 1'b0;
            hold_remaining--;
        end
        else
            rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // ------------------------------------------------------------------------
    // Sender tasks. Each is entered and left just after a rising edge.
    // ------------------------------------------------------------------------

    // Offer one request word. Insert random idle cycles first, then hold the
    // word until accepted. Leave valid high so a following word can go back
    // to back.
    task automatic offer_request(input spq_pkg::req_t w);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= w;
        do
            @(posedge clk);
        while (!req_ready);
    endtask

    task automatic stop_sender();
        req_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Wait until every predicted response word has come back, then let the
    // pipeline settle.
    task automatic wait_drain();
        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Write the capacity register, with the unit idle.
    task automatic write_capacity(input logic [spq_pkg::CAP_BITS-1:0] value);
        stop_sender();
        wait_drain();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic spq_pkg::req_t make_request(input spq_pkg::op_t op,
                                                   input logic [15:0] prio,
                                                   input logic [31:0] data);
        spq_pkg::req_t w;
        w.opcode       = op;
        w.priority_req = prio;
        w.payload      = data;
        return w;
    endfunction

    // Random request word. Mode picks the priority spread: full range, a
    // narrow range that forces ties, or the two extremes.
    function automatic spq_pkg::req_t random_request(input int enq_pct, input int mode);
        spq_pkg::op_t op;
        logic [15:0]  prio;
        op = ($urandom_range(99) < enq_pct) ? spq_pkg::OP_ENQ : spq_pkg::OP_DEQ;
        if (mode < 5)
            prio = 16'($urandom);
        else if (mode < 8)
            prio = 16'($urandom_range(7));
        else
            prio = $urandom_range(1) ? 16'hFFFF : 16'h0000;
        return make_request(op, prio, $urandom);
    endfunction

    // Run n random words in batches; most batches lean toward filling or
    // draining so the queue swings between empty and full.
    task automatic run_traffic(input int n);
        int left;
        int batch;
        int enq_pct;
        int mode;
        left = n;
        while (left > 0)
        begin
            batch = $urandom_range(6, 24);
            if (batch > left)
                batch = left;
            case ($urandom_range(3))
                0:       enq_pct = 25;
                1:       enq_pct = 50;
                2:       enq_pct = 70;
                default: enq_pct = 90;
            endcase
            mode = $urandom_range(9);
            repeat (batch) offer_request(random_request(enq_pct, mode));
            left -= batch;
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Hand-picked words: empty and full refusals, priority extremes, ties,
    // and capacity clamped at both ends or lowered below the count.
    task automatic test_directed_cases();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        // Keep the capacity at its reset value for the first words.
        offer_request(make_request(spq_pkg::OP_DEQ, 16'h1234, 32'h5555_AAAA));
        offer_request(make_request(spq_pkg::OP_ENQ, 16'hFFFF, 32'hFFFF_FFFF));
        offer_request(make_request(spq_pkg::OP_ENQ, 16'h0000, 32'h0000_0000));
        offer_request(make_request(spq_pkg::OP_ENQ, 16'h8000, 32'h1111_1111));
        offer_request(make_request(spq_pkg::OP_ENQ, 16'h8000, 32'h2222_2222));
        repeat (5) offer_request(make_request(spq_pkg::OP_DEQ, 16'h0000, 32'h0));
        // Capacity two: fill it and have the third word refused.
        write_capacity(5'd2);
        offer_request(make_request(spq_pkg::OP_ENQ, 16'd5, 32'hA5A5_0005));
        offer_request(make_request(spq_pkg::OP_ENQ, 16'd3, 32'hA5A5_0003));
        offer_request(make_request(spq_pkg::OP_ENQ, 16'd1, 32'hA5A5_0001));
        // Capacity zero acts as one, now below the count of two.
        write_capacity(5'd0);
        offer_request(make_request(spq_pkg::OP_ENQ, 16'd2, 32'hDEAD_0002));
        offer_request(make_request(spq_pkg::OP_DEQ, 16'd0, 32'h0));
        offer_request(make_request(spq_pkg::OP_DEQ, 16'd0, 32'h0));
        offer_request(make_request(spq_pkg::OP_ENQ, 16'd7, 32'hBEEF_0007));
        offer_request(make_request(spq_pkg::OP_ENQ, 16'd6, 32'hBEEF_0006));
        // Capacity past the depth acts as the depth.
        write_capacity(5'd31);
        offer_request(make_request(spq_pkg::OP_ENQ, 16'd7, 32'hCAFE_0007));
        offer_request(make_request(spq_pkg::OP_DEQ, 16'd0, 32'h0));
        offer_request(make_request(spq_pkg::OP_DEQ, 16'd0, 32'h0));
        stop_sender();
    endtask

    // Random traffic over every idling phase and several capacities.
    task automatic test_random_phases();
        int                           ph;
        int                           c;
        logic [spq_pkg::CAP_BITS-1:0] cap;
        for (ph = 0; ph < 4; ph++)
        begin
            stop_sender();
            wait_drain();
            case (ph)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 51; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 51; end
                default: begin send_idle_pct = 20; recv_stall_pct = 20; end
            endcase
            for (c = 0; c < 5; c++)
            begin
                case (c)
                    0:       cap = 5'd16;
                    1:       cap = 5'd1;
                    2:       cap = 5'd0;
                    3:       cap = 5'd31;
                    default: cap = 5'($urandom_range(2, 15));
                endcase
                write_capacity(cap);
                run_traffic(58);
            end
        end
        stop_sender();
    endtask

    // Hold off the receiver for a long stretch while words keep coming so
    // the unit stalls its input; then pause until everything drains.
    task automatic test_output_stall();
        write_capacity(5'd16);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_remaining = 300;
        run_traffic(40);
        stop_sender();
        wait_drain();
        recv_stall_pct = 30;
        run_traffic(20);
        stop_sender();
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n          = 1'b0;
        req_valid      = 1'b0;
        req            = '0;
        rsp_ready      = 1'b0;
        cfg_valid      = 1'b0;
        cfg_data       = '0;
        shadow_count   = 0;
        shadow_cap     = spq_pkg::CAP_BITS'(spq_pkg::CAP_RESET);
        error_count    = 0;
        quiet_cycles   = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_remaining = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_cases();
        test_random_phases();
        test_output_stall();

        wait_drain();
        repeat (8) @(posedge clk);
        if (pending_rsp.size() != 0)
            error_count++;
        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
